// ===== rtl/tplt_pkg.sv =====
// tplt_pkg: shared constants, types and the quarter-sine entry generator
// for the two-partial lfo tremolo. No dependencies.
`default_nettype none

package tplt_pkg;

  // default parameter values of the top level
  localparam int TPLT_CHANNELS        = 2;
  localparam int TPLT_PHASE_BITS      = 24;
  localparam int TPLT_SINE_TABLE_BITS = 10;
  localparam int TPLT_SAMPLE_BITS     = 24;

  // fixed widths of the configuration port
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;

  // q1.15 unity
  localparam logic [16:0] Q15_ONE = 17'd32768;

  // pi/2 scaled by 2^30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PHASE_INC = 2'd0,
    CFG_DEPTH     = 2'd1,
    CFG_MIX       = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_OUT
  } state_t;

  // sin(pi/2 * k / 2^tab_bits) in q15, taylor series in q30, elaboration only
  function automatic logic [15:0] sine_entry(int k, int tab_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    begin
      x    = (HALF_PI_Q30 * 64'(k)) >> tab_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n < 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      r = ($unsigned(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      return r[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/two_partial_lfo_tremolo.sv =====
// Two-partial lfo tremolo: a sequencer around one shared multiplier and a quarter-sine rom.
// Depends on tplt_pkg.
//
// Each accepted item goes through these steps: two reads of the registered quarter-sine
// rom (sine of the phase, sine of twice the phase), then four passes through the single
// shared signed multiplier (first partial, second partial and blend, depth term, sample
// scaling), then the load of the output register. The block takes a new item only once
// the previous one has reached the output register, which is loaded when it is empty or
// the result side does not stall it. Channels at or above CHANNELS pass the sample through
// unchanged without touching any phase. The rom is a constant table of 2^SINE_TABLE_BITS+1
// entries built at elaboration; no clearing pass is needed after reset. Configuration
// writes are taken in any cycle and must only be issued while no item is in flight.
`default_nettype none

module two_partial_lfo_tremolo
  import tplt_pkg::*;
#(
  parameter int CHANNELS        = TPLT_CHANNELS,
  parameter int PHASE_BITS      = TPLT_PHASE_BITS,
  parameter int SINE_TABLE_BITS = TPLT_SINE_TABLE_BITS,
  parameter int SAMPLE_BITS     = TPLT_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  wire logic                          in_channel,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic                               out_channel_out,

  input  wire logic                          cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int TAB_N    = 1 << SINE_TABLE_BITS;
  localparam int ADDR_W   = SINE_TABLE_BITS + 1;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW       = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
  localparam int BW       = 18;
  localparam int PW       = AW + BW;
  localparam int EXT_W    = PHASE_BITS - 2 + SINE_TABLE_BITS;

  typedef logic [15:0] rom_t [TAB_N+1];

  function automatic rom_t build_rom();
    rom_t r;
    begin
      for (int k = 0; k <= TAB_N; k++) begin
        r[k] = sine_entry(k, SINE_TABLE_BITS);
      end
      return r;
    end
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // configuration
  logic [PHASE_BITS-1:0] inc_r;
  logic [15:0]           depth_r;
  logic [15:0]           mix_r;
  logic [15:0]           cfg_sat;

  // per-channel lfo phase
  logic [PHASE_BITS-1:0] lfo_phase_r [CHANNELS];

  // sequencer and datapath
  state_t                   state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                     channel_r;
  logic [CH_IDX_W-1:0]      ch_idx_r;
  logic [PHASE_BITS-1:0]    p_r;
  logic [PHASE_BITS-1:0]    p2;
  logic [PHASE_BITS-1:0]    sel_ph;
  logic [EXT_W-1:0]         ph_ext;
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [ADDR_W-1:0]        rom_addr;
  logic                     rom_neg;
  logic [15:0]              rom_q_r;
  logic                     rom_neg_r;
  logic signed [16:0]       rom_signed;
  logic signed [16:0]       s1_r;
  logic signed [16:0]       s2_r;
  logic signed [31:0]       acc_r;
  logic signed [31:0]       blend_sum;
  logic signed [16:0]       mod_r;
  logic [16:0]              dterm;
  logic [15:0]              gain_r;
  logic signed [SAMPLE_BITS-1:0] result_r;
  logic                     ch_ok;
  logic                     in_fire;
  logic                     out_load;

  logic signed [AW-1:0]     mul_a;
  logic signed [BW-1:0]     mul_b;
  logic signed [PW-1:0]     prod;

  logic                     out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                     out_channel_r;

  assign in_fire = in_valid && !in_stall;
  assign ch_ok   = (32'(in_channel) < CHANNELS);

  // configuration writes, depth and mix saturate at unity
  assign cfg_sat = (cfg_data[15:0] > 16'(Q15_ONE)) ? 16'(Q15_ONE) : cfg_data[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r   <= '0;
      depth_r <= '0;
      mix_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_INC: inc_r   <= PHASE_BITS'(cfg_data);
        CFG_DEPTH:     depth_r <= cfg_sat;
        CFG_MIX:       mix_r   <= cfg_sat;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = ch_ok ? S_RD1 : S_OUT;
        end
      end
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_MUL4;
      S_MUL4: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer outputs: handshake, rom address and multiplier operands
  assign p2 = {p_r[PHASE_BITS-2:0], 1'b0};

  always_comb begin
    in_stall = (state_r != S_IDLE);
    sel_ph   = (state_r == S_RD2) ? p2 : p_r;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      S_MUL1: begin
        mul_a = AW'(s1_r);
        mul_b = $signed({1'b0, Q15_ONE - {1'b0, mix_r}});
      end
      S_MUL2: begin
        mul_a = AW'(s2_r);
        mul_b = $signed({2'b00, mix_r});
      end
      S_MUL3: begin
        mul_a = $signed(AW'(depth_r));
        mul_b = $signed(BW'(Q15_ONE)) - BW'(mod_r);
      end
      S_MUL4: begin
        mul_a = AW'(sample_r);
        mul_b = $signed({2'b00, gain_r});
      end
      default: ;
    endcase
  end

  // quadrant fold of the phase, index zero-filled when the phase is narrower than the table
  assign ph_ext   = {sel_ph[PHASE_BITS-3:0], {SINE_TABLE_BITS{1'b0}}};
  assign tab_idx  = ph_ext[EXT_W-1 -: SINE_TABLE_BITS];
  assign rom_addr = sel_ph[PHASE_BITS-2] ? (ADDR_W'(TAB_N) - {1'b0, tab_idx})
                                         : {1'b0, tab_idx};
  assign rom_neg  = sel_ph[PHASE_BITS-1];

  always_ff @(posedge clk) begin
    rom_q_r   <= SINE_ROM[rom_addr];
    rom_neg_r <= rom_neg;
  end

  assign rom_signed = rom_neg_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});

  // shared multiplier
  assign prod      = mul_a * mul_b;
  assign blend_sum = 32'(prod) + acc_r;
  assign dterm     = 17'(prod >>> 16);

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sample_r  <= in_sample_in;
          channel_r <= in_channel;
          ch_idx_r  <= CH_IDX_W'(in_channel);
          result_r  <= in_sample_in;
          p_r       <= ch_ok ? lfo_phase_r[CH_IDX_W'(in_channel)] : '0;
        end
      end
      S_RD2:  s1_r     <= rom_signed;
      S_MUL1: begin
        s2_r  <= rom_signed;
        acc_r <= 32'(prod);
      end
      // floor shift of the blended partials
      S_MUL2: mod_r    <= 17'(blend_sum >>> 15);
      S_MUL3: gain_r   <= 16'(Q15_ONE - dterm);
      S_MUL4: result_r <= SAMPLE_BITS'(prod >>> 15);
      default: ;
    endcase
  end

  // phase advances once the gain has used the old value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lfo_phase_r[c] <= '0;
      end
    end else if (state_r == S_MUL4) begin
      lfo_phase_r[ch_idx_r] <= p_r + inc_r;
    end
  end

  // output register
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r  <= result_r;
      out_channel_r <= channel_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_channel_out = out_channel_r;

endmodule

`default_nettype wire
